@@ hdl/prfe_pkg.sv @@
package prfe_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 640;
  localparam int unsigned SCREEN_HEIGHT_DEF = 480;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned SPAN_W = 13;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned ADDR_IN_W = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEVEL_HALF = 127;

  typedef enum logic [1:0] {
    FUNC_FILL  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // One decoded command handed from the front to the back.
  // Coordinates are the clipped rectangle in pixels, x1/y1 exclusive.
  typedef struct packed {
    func_t       func;
    logic        empty;
    logic [11:0] x0;
    logic [11:0] x1;
    logic [11:0] y0;
    logic [11:0] y1;
    logic [3:0]  on;
    logic [15:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bright;
    logic       nothing_drawn;
  } res_t;

  // Left-edge mask: pixels from bit offset s to the end of the byte.
  function automatic logic [7:0] mask_from(input logic [2:0] s);
    mask_from = 8'hFF >> s;
  endfunction

  // Right-edge mask: pixels up to and including bit offset e.
  function automatic logic [7:0] mask_upto(input logic [2:0] e);
    mask_upto = 8'hFF << (3'd7 - e);
  endfunction

endpackage

@@ hdl/prfe_if.sv @@
interface prfe_in_if import prfe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic signed [11:0]  left;
  logic signed [11:0]  top;
  logic signed [12:0]  span_w;
  logic signed [12:0]  span_h;
  logic [7:0]          red;
  logic [7:0]          green;
  logic [7:0]          blue;
  logic [15:0]         byte_addr;
  modport source (output valid, func, left, top, span_w, span_h, red, green, blue,
                  byte_addr, input ready);
  modport sink (input valid, func, left, top, span_w, span_h, red, green, blue,
                byte_addr, output ready);
endinterface

interface prfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_bright;
  logic       nothing_drawn;
  modport source (output valid, out_red, out_green, out_blue, out_bright,
                  nothing_drawn, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_bright,
                nothing_drawn, output ready);
endinterface

@@ hdl/planar_rect_fill_engine.sv @@
// Channel   | Direction | Payload
// in_ch     | sink      | func, left, top, span_w, span_h, red, green, blue, byte_addr
// out_ch    | source    | out_red, out_green, out_blue, out_bright, nothing_drawn
//
// A request is held in the front decode register, then the back end
// works it: a fill reads then writes the plane memory for each byte of the clipped
// rectangle, a clear writes every byte
// ((SCREEN_WIDTH+7)/8*SCREEN_HEIGHT), a read fetches one word; every request passes
// S_DONE to post its result, which then waits in a register and blocks the back end.
// Reset is synchronous, active low; memory content is not reset.
module planar_rect_fill_engine import prfe_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  prfe_in_if.sink    in_ch,
  prfe_out_if.source out_ch
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // Decode and clip each request.
  prfe_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  // Walk the plane memory.
  prfe_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .out_ch(out_ch)
  );

  // Back end never takes a request while a result still waits.
  a_no_take_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !cmd_ready) else $error("took request");

  // A result that is not taken holds.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");

  // An empty fill, flagged nothing_drawn, reports a zero red byte.
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.nothing_drawn) |-> (out_ch.out_red == 8'd0))
    else $error("bad flag");
endmodule

@@ hdl/prfe_ram.sv @@
module prfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 38400
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/prfe_front.sv @@
module prfe_front import prfe_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  prfe_in_if.sink in_ch,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);
  // Clip and classify in one registered stage.
  logic signed [13:0] x1_w, y1_w, x0_w, y0_w;
  logic               empty_w;
  logic [3:0]         on_w;
  cmd_t               cmd_r, cmd_nxt;
  logic               valid_r;

  assign in_ch.ready = !valid_r || cmd_ready;

  always_comb begin
    x0_w = (in_ch.left < 0) ? 14'sd0 : 14'(in_ch.left);
    y0_w = (in_ch.top < 0) ? 14'sd0 : 14'(in_ch.top);
    x1_w = 14'(in_ch.left) + 14'(in_ch.span_w);
    y1_w = 14'(in_ch.top) + 14'(in_ch.span_h);
    if (x1_w > $signed(14'(SCREEN_WIDTH))) x1_w = $signed(14'(SCREEN_WIDTH));
    if (y1_w > $signed(14'(SCREEN_HEIGHT))) y1_w = $signed(14'(SCREEN_HEIGHT));
    empty_w = (in_ch.span_w <= 0) || (in_ch.span_h <= 0) || (x0_w >= x1_w) ||
              (y0_w >= y1_w);
    on_w = {in_ch.red != 8'd0, in_ch.green != 8'd0, in_ch.blue != 8'd0,
            (in_ch.red > 8'(LEVEL_HALF)) || (in_ch.green > 8'(LEVEL_HALF)) ||
            (in_ch.blue > 8'(LEVEL_HALF))};
    cmd_nxt.func  = func_t'(in_ch.func);
    cmd_nxt.empty = empty_w;
    cmd_nxt.x0    = x0_w[11:0];
    cmd_nxt.x1    = x1_w[11:0];
    cmd_nxt.y0    = y0_w[11:0];
    cmd_nxt.y1    = y1_w[11:0];
    cmd_nxt.on    = on_w;
    cmd_nxt.addr  = in_ch.byte_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd = cmd_r;
endmodule

@@ hdl/prfe_back.sv @@
module prfe_back import prfe_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  prfe_out_if.source out_ch
);
  localparam int unsigned ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
  localparam int unsigned DEPTH = ROW_BYTES * SCREEN_HEIGHT;
  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_WR    = 6'b000100,
    S_CLR   = 6'b001000,
    S_FETCH = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t       state_r, state_nxt;
  cmd_t         c_r;
  logic [8:0]   bx_r, bx_nxt;
  logic [11:0]  y_r, y_nxt;
  logic [AW-1:0] row_r, row_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [8:0]   bx_first, bx_last;
  logic [7:0]   mask_w;
  logic [31:0]  wide_w, setm_w, rdata, wdata;
  logic         we;
  logic [AW-1:0] waddr, raddr;
  res_t         res_r, res_nxt;
  logic         out_v_r;

  prfe_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign bx_first = c_r.x0[11:3];
  assign bx_last  = 9'((c_r.x1 - 12'd1) >> 3);

  always_comb begin
    mask_w = 8'hFF;
    if (bx_r == bx_first) mask_w = mask_w & mask_from(c_r.x0[2:0]);
    if (bx_r == bx_last) mask_w = mask_w & mask_upto(3'(c_r.x1 - 12'd1));
    wide_w = {4{mask_w}};
    setm_w = {c_r.on[3] ? mask_w : 8'h00, c_r.on[2] ? mask_w : 8'h00,
              c_r.on[1] ? mask_w : 8'h00, c_r.on[0] ? mask_w : 8'h00};
  end

  assign cmd_ready = (state_r == S_IDLE) && !out_v_r;

  always_comb begin
    state_nxt = state_r;
    bx_nxt = bx_r;
    y_nxt = y_r;
    row_nxt = row_r;
    clr_nxt = clr_r;
    res_nxt = res_r;
    we = 1'b0;
    waddr = row_r + AW'(bx_r);
    wdata = (rdata & ~wide_w) | setm_w;
    raddr = row_r + AW'(bx_r);
    unique case (state_r)
      S_IDLE: begin
        raddr = cmd.addr[AW-1:0];
        if (cmd_valid && cmd_ready) begin
          res_nxt = '0;
          bx_nxt = cmd.x0[11:3];
          y_nxt = cmd.y0;
          row_nxt = AW'(cmd.y0 * ROW_BYTES);
          clr_nxt = '0;
          unique case (cmd.func)
            FUNC_FILL: begin
              res_nxt.nothing_drawn = cmd.empty;
              state_nxt = cmd.empty ? S_DONE : S_FETCH;
            end
            FUNC_CLEAR: state_nxt = S_CLR;
            FUNC_READ: state_nxt = (32'(cmd.addr) < DEPTH) ? S_RD : S_DONE;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RD: begin
        {res_nxt.red, res_nxt.green, res_nxt.blue, res_nxt.bright} = rdata;
        state_nxt = S_DONE;
      end
      S_FETCH: state_nxt = S_WR;
      S_WR: begin
        we = 1'b1;
        if (bx_r == bx_last) begin
          bx_nxt = bx_first;
          y_nxt = y_r + 12'd1;
          row_nxt = row_r + AW'(ROW_BYTES);
          state_nxt = (y_r + 12'd1 == c_r.y1) ? S_DONE : S_FETCH;
        end else begin
          bx_nxt = bx_r + 9'd1;
          state_nxt = S_FETCH;
        end
        raddr = row_nxt + AW'(bx_nxt);
      end
      S_CLR: begin
        we = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + AW'(1);
        if (32'(clr_r) == DEPTH - 1) state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
    if (cmd_valid && cmd_ready) c_r <= cmd;
    bx_r <= bx_nxt;
    y_r <= y_nxt;
    row_r <= row_nxt;
    clr_r <= clr_nxt;
    res_r <= res_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.out_red = res_r.red;
  assign out_ch.out_green = res_r.green;
  assign out_ch.out_blue = res_r.blue;
  assign out_ch.out_bright = res_r.bright;
  assign out_ch.nothing_drawn = res_r.nothing_drawn;
endmodule
